// ----- design/isc_pkg.sv -----
// shared constants and types for the insertion sort unit
// no dependencies; used by isc_cell and insertion_sort_with_counts_unit

package isc_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned TDATA_W = ((DATA_W + 2 * CNT_W + 1 + 7) / 8) * 8;

  // per-cell control, broadcast from the top level
  typedef struct packed {
    logic insert;     // new element enters the chain
    logic shift_cnt;  // shift per-cell counters toward cell 0
    logic shift_val;  // shift stored values toward cell 0
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SUM  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

// ----- design/isc_cell.sv -----
// one cell of the sorting chain: a stored value and its shift counter
// depends on isc_pkg

module isc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isc_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [isc_pkg::DATA_W-1:0]   din_i,
  input  logic                                occ_i,
  input  logic                                left_occ_i,
  input  logic                                left_gt_i,
  input  logic signed [isc_pkg::DATA_W-1:0]   left_val_i,
  input  logic signed [isc_pkg::DATA_W-1:0]   right_val_i,
  input  logic        [isc_pkg::IDX_W-1:0]    right_cnt_i,
  output logic                                gt_o,
  output logic signed [isc_pkg::DATA_W-1:0]   val_o,
  output logic        [isc_pkg::IDX_W-1:0]    cnt_o
);

  logic signed [isc_pkg::DATA_W-1:0] val_q, val_d;
  logic        [isc_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  logic                              take;

  // stored entry greater than the new one: it moves one place up
  assign gt_o = occ_i && (val_q > din_i);
  // this cell changes: it shifts, or it is the first free slot
  assign take = gt_o || (!occ_i && left_occ_i);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert && take) begin
      val_d = left_gt_i ? left_val_i : din_i;
    end else if (ctrl_i.shift_val) begin
      val_d = right_val_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.insert && gt_o) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.shift_cnt) begin
      cnt_d = right_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign val_o = val_q;
  assign cnt_o = cnt_q;

endmodule

// ----- design/insertion_sort_with_counts_unit.sv -----
// top level of the streaming insertion sort with operation counts
// depends on isc_pkg and isc_cell

// usage:
// - slave channel: one signed 32-bit element per beat, tlast on the final
//   element of an array; one beat is taken per cycle while loading
// - each element is placed in the sorted chain in the cycle it is taken;
//   elements arriving with the chain full (DEPTH entries) are dropped and
//   the overflow flag is set for that array
// - after the tlast beat, tready stays low: the per-cell shift counters are
//   swept into the totals, then the chain drains toward cell 0
// - the first result beat follows the counter sweep, then one beat per cycle
//   while the master side accepts, ascending, tlast on the final one
// - every result beat carries the comparison and move totals and overflow
// - a stall on the master side holds the output register and the chain;
//   tready rises again after the last result is loaded into the output
//   register, whether or not that beat has been taken yet
// - reset empties the chain, clears counters and flags, no beat pending

module insertion_sort_with_counts_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [isc_pkg::DATA_W-1:0]          s_axis_tdata_i,  // [31:0] value
  input  logic                                s_axis_tlast_i,  // last_in
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] sorted_value, [43:32] comp_count, [55:44] move_count,
  // [56] overflow, [63:57] zero
  output logic [isc_pkg::TDATA_W-1:0]         m_axis_tdata_o,
  output logic                                m_axis_tlast_o  // last_out
);

  localparam int unsigned D  = isc_pkg::DEPTH;
  localparam int unsigned DW = isc_pkg::DATA_W;
  localparam int unsigned CW = isc_pkg::CNT_W;
  localparam int unsigned FW = isc_pkg::FILL_W;
  localparam int unsigned IW = isc_pkg::IDX_W;

  isc_pkg::state_e     state_q, state_d;
  isc_pkg::cell_ctrl_t ctrl;

  logic [FW-1:0] fill_q, fill_d;      // entries held in the chain
  logic [FW-1:0] sweep_q, sweep_d;    // counter sweep position
  logic [FW-1:0] rem_q, rem_d;        // results still to emit
  logic [CW-1:0] acc_q, acc_d;        // total shifts over the array
  logic          drop_q, drop_d;      // element dropped in this array

  logic          out_valid_q, out_valid_d;
  logic          out_last_q;
  logic [DW-1:0] out_val_q;
  logic [CW-1:0] out_comp_q, out_move_q;
  logic          out_ovf_q;

  logic          in_beat, full, out_load, emit_beat;
  logic [CW-1:0] base_cnt, comp_tot, move_tot;

  // chain wiring
  logic signed [DW-1:0] cell_val [D];
  logic        [IW-1:0] cell_cnt [D];
  logic        [D-1:0]  cell_gt;
  logic        [D-1:0]  occ;

  assign full            = (fill_q == FW'(D));
  assign s_axis_tready_o = (state_q == isc_pkg::ST_LOAD);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign emit_beat       = (state_q == isc_pkg::ST_EMIT) && out_load && (rem_q != '0);

  assign ctrl.insert    = in_beat && !full;
  assign ctrl.shift_cnt = (state_q == isc_pkg::ST_SUM);
  assign ctrl.shift_val = emit_beat;

  // first element counts nothing, each later one one compare and two moves,
  // plus one of each per shifted entry
  assign base_cnt = CW'(fill_q) - 1'b1;
  assign comp_tot = acc_q + base_cnt;
  assign move_tot = acc_q + {base_cnt[CW-2:0], 1'b0};

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [DW-1:0] lval, rval;
    logic        [IW-1:0] rcnt;
    logic                 locc, lgt;

    assign occ[i] = (fill_q > FW'(i));

    if (i == 0) begin : g_head
      assign locc = 1'b1;
      assign lgt  = 1'b0;
      assign lval = '0;
    end else begin : g_body
      assign locc = occ[i-1];
      assign lgt  = cell_gt[i-1];
      assign lval = cell_val[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign rval = '0;
      assign rcnt = '0;
    end else begin : g_inner
      assign rval = cell_val[i+1];
      assign rcnt = cell_cnt[i+1];
    end

    isc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .din_i       (s_axis_tdata_i),
      .occ_i       (occ[i]),
      .left_occ_i  (locc),
      .left_gt_i   (lgt),
      .left_val_i  (lval),
      .right_val_i (rval),
      .right_cnt_i (rcnt),
      .gt_o        (cell_gt[i]),
      .val_o       (cell_val[i]),
      .cnt_o       (cell_cnt[i])
    );
  end

  // control sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sweep_d     = sweep_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;

    if (out_load) begin
      out_valid_d = emit_beat;
    end

    case (state_q)
      isc_pkg::ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          if (s_axis_tlast_i) begin
            sweep_d = '0;
            state_d = isc_pkg::ST_SUM;
          end
        end
      end
      isc_pkg::ST_SUM: begin
        // cell 0 counter is summed while the row shifts toward it
        acc_d   = acc_q + CW'(cell_cnt[0]);
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == FW'(D - 1)) begin
          rem_d   = fill_q;
          state_d = isc_pkg::ST_EMIT;
        end
      end
      isc_pkg::ST_EMIT: begin
        if (emit_beat) begin
          rem_d = rem_q - 1'b1;
        end else if (rem_q == '0) begin
          // everything handed to the output register: start a new array
          fill_d  = '0;
          acc_d   = '0;
          drop_d  = 1'b0;
          state_d = isc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = isc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isc_pkg::ST_LOAD;
      fill_q      <= '0;
      sweep_q     <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sweep_q     <= sweep_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register, payload only
  always_ff @(posedge clk_i) begin
    if (emit_beat) begin
      out_val_q  <= cell_val[0];
      out_last_q <= (rem_q == FW'(1));
      out_comp_q <= comp_tot;
      out_move_q <= move_tot;
      out_ovf_q  <= drop_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = isc_pkg::TDATA_W'({out_ovf_q, out_move_q, out_comp_q, out_val_q});

endmodule
